// File: hdl/llh_pkg.sv
//------------------------------------------------------------------------------
// llh_pkg
// Shared types, constants and helper functions of the log2 latency histogram.
//------------------------------------------------------------------------------
`default_nettype none

package llh_pkg;

  localparam int CMD_W     = 2;
  localparam int SAMPLE_W  = 64;
  localparam int FRAC_W    = 17;
  localparam int VAL_W     = 63;
  localparam int CNT_OUT_W = 32;
  localparam int LOG_W     = 6;
  localparam int ACC_W     = 64;

  localparam logic [ACC_W-1:0] CNT_OUT_MAX = 64'h0000_0000_FFFF_FFFF;

  typedef enum logic [CMD_W-1:0] {
    CMD_RECORD = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_code_t;

  typedef enum logic [1:0] {
    PV_HOLD = 2'd0,
    PV_ZERO = 2'd1,
    PV_HIT  = 2'd2,
    PV_MAX  = 2'd3
  } pv_sel_t;

  typedef struct packed {
    logic    load;
    logic    rec_upd;
    logic    clr;
    logic    mul_step;
    logic    scan_start;
    logic    scan_step;
    pv_sel_t pv_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic mul_done;
    logic hit;
    logic last;
  } dp_status_t;

  // Index of the highest set bit; 0 and 1 both give 0.
  function automatic logic [LOG_W-1:0] floor_log2(input logic [VAL_W-1:0] v);
    logic [LOG_W-1:0] n;
    n = '0;
    for (int i = 1; i < VAL_W; i++) begin
      if (v[i]) n = LOG_W'(i);
    end
    return n;
  endfunction

  function automatic logic [ACC_W-1:0] sat_add64(input logic [ACC_W-1:0] a,
                                                 input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? '1 : s[ACC_W-1:0];
  endfunction

  // Upper bound 2^(i+1)-1 of a bucket, capped at the largest 63-bit value.
  function automatic logic [VAL_W-1:0] bucket_bound(input logic [LOG_W-1:0] idx);
    logic [VAL_W-1:0] b;
    if (idx >= LOG_W'(VAL_W - 1)) begin
      b = '1;
    end else begin
      b = (VAL_W'(1) << (idx + LOG_W'(1))) - VAL_W'(1);
    end
    return b;
  endfunction

endpackage

`default_nettype wire

// File: hdl/llh_if.sv
//------------------------------------------------------------------------------
// llh_if
// Valid/ready channels carrying histogram commands and their results.
//------------------------------------------------------------------------------
`default_nettype none

interface llh_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [llh_pkg::CMD_W-1:0]            command;
  logic signed [llh_pkg::SAMPLE_W-1:0]  sample;
  logic [llh_pkg::FRAC_W-1:0]           fraction;

  modport source (output valid, command, sample, fraction, input ready);
  modport sink   (input valid, command, sample, fraction, output ready);
endinterface

interface llh_out_if;
  logic                             valid;
  logic                             ready;
  logic [llh_pkg::VAL_W-1:0]        percentile_value;
  logic [llh_pkg::VAL_W-1:0]        min_seen;
  logic [llh_pkg::VAL_W-1:0]        max_seen;
  logic [llh_pkg::CNT_OUT_W-1:0]    sample_count;

  modport source (output valid, percentile_value, min_seen, max_seen, sample_count,
                  input ready);
  modport sink   (input valid, percentile_value, min_seen, max_seen, sample_count,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/llh_ctrl.sv
//------------------------------------------------------------------------------
// llh_ctrl
// Sequencer for record, query and clear transactions of the histogram.
//------------------------------------------------------------------------------
`default_nettype none

module llh_ctrl (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [llh_pkg::CMD_W-1:0]  in_command,
  output logic                            in_ready,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  input  wire llh_pkg::dp_status_t        st,
  output llh_pkg::dp_cmd_t                cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_REC  = 5'b00010,
    S_MUL  = 5'b00100,
    S_SCAN = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd.load       = 1'b0;
    cmd.rec_upd    = 1'b0;
    cmd.clr        = 1'b0;
    cmd.mul_step   = 1'b0;
    cmd.scan_start = 1'b0;
    cmd.scan_step  = 1'b0;
    cmd.pv_sel     = llh_pkg::PV_HOLD;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          case (in_command)
            llh_pkg::CMD_RECORD: begin
              state_nxt = S_REC;
            end
            llh_pkg::CMD_QUERY: begin
              if (st.total_zero) begin
                cmd.pv_sel = llh_pkg::PV_ZERO;
                state_nxt  = S_OUT;
              end else begin
                state_nxt = S_MUL;
              end
            end
            llh_pkg::CMD_CLEAR: begin
              cmd.clr    = 1'b1;
              cmd.pv_sel = llh_pkg::PV_ZERO;
              state_nxt  = S_OUT;
            end
            default: begin
              cmd.pv_sel = llh_pkg::PV_ZERO;
              state_nxt  = S_OUT;
            end
          endcase
        end
      end
      S_REC: begin
        cmd.rec_upd = 1'b1;
        cmd.pv_sel  = llh_pkg::PV_ZERO;
        state_nxt   = S_OUT;
      end
      S_MUL: begin
        if (st.mul_done) begin
          cmd.scan_start = 1'b1;
          state_nxt      = S_SCAN;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (st.hit) begin
          cmd.pv_sel = llh_pkg::PV_HIT;
          state_nxt  = S_OUT;
        end else if (st.last) begin
          cmd.pv_sel = llh_pkg::PV_MAX;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input ready while a result is pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready stayed high after an accepted transaction");

endmodule

`default_nettype wire

// File: hdl/llh_dp.sv
//------------------------------------------------------------------------------
// llh_dp
// Bucket memory, counters, extremes, shift-add target multiplier and scan.
//------------------------------------------------------------------------------
`default_nettype none

module llh_dp #(
  parameter int NUM_BUCKETS = 64,
  parameter int COUNT_BITS  = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire llh_pkg::dp_cmd_t                     cmd,
  output llh_pkg::dp_status_t                       st,
  input  wire logic signed [llh_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire logic [llh_pkg::FRAC_W-1:0]           in_fraction,
  output logic [llh_pkg::VAL_W-1:0]                 out_percentile_value,
  output logic [llh_pkg::VAL_W-1:0]                 out_min_seen,
  output logic [llh_pkg::VAL_W-1:0]                 out_max_seen,
  output logic [llh_pkg::CNT_OUT_W-1:0]             out_sample_count
);

  localparam int IDX_W = $clog2(NUM_BUCKETS);
  localparam int PW    = COUNT_BITS + llh_pkg::FRAC_W;
  localparam int TW    = PW - 16;

  // Histogram state.
  logic [COUNT_BITS-1:0]      mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0]     valid_r;
  logic [COUNT_BITS-1:0]      total_r;
  logic [llh_pkg::VAL_W-1:0]  min_r;
  logic [llh_pkg::VAL_W-1:0]  max_r;

  // Per-transaction working registers.
  logic [llh_pkg::VAL_W-1:0]  sample_r;
  logic [IDX_W-1:0]           bkt_r;
  logic [llh_pkg::FRAC_W-1:0] frac_r;
  logic [PW-1:0]              mcand_r;
  logic [PW-1:0]              prod_r;
  logic [IDX_W-1:0]           scan_idx_r;
  logic [llh_pkg::ACC_W-1:0]  acc_r;
  logic [COUNT_BITS-1:0]      rd_q_r;
  logic                       vld_q_r;
  logic [llh_pkg::VAL_W-1:0]  pv_r;

  logic [llh_pkg::VAL_W-1:0]  in_clamped;
  logic [llh_pkg::LOG_W-1:0]  in_log;
  logic [IDX_W-1:0]           in_bkt;
  logic [IDX_W-1:0]           rd_addr;
  logic [COUNT_BITS-1:0]      cnt_cur;
  logic [COUNT_BITS-1:0]      cnt_inc;
  logic [TW-1:0]              tgt_full;
  logic [llh_pkg::ACC_W:0]    tgt_ext;
  logic [llh_pkg::ACC_W-1:0]  target;
  logic [llh_pkg::ACC_W-1:0]  acc_sum;
  logic                       scan_last;
  logic [llh_pkg::ACC_W-1:0]  total_ext;

  assign in_clamped = in_sample[llh_pkg::SAMPLE_W-1] ? '0 : in_sample[llh_pkg::VAL_W-1:0];
  assign in_log     = llh_pkg::floor_log2(in_clamped);
  assign in_bkt     = (7'(in_log) > 7'(NUM_BUCKETS - 1)) ? IDX_W'(NUM_BUCKETS - 1)
                                                          : IDX_W'(in_log);

  assign scan_last = (scan_idx_r == IDX_W'(NUM_BUCKETS - 1));

  always_comb begin
    if (cmd.scan_start) begin
      rd_addr = '0;
    end else if (cmd.scan_step) begin
      rd_addr = scan_last ? '0 : scan_idx_r + IDX_W'(1);
    end else begin
      rd_addr = in_bkt;
    end
  end

  // A bucket without its valid bit reads as zero, so a clear only drops the bits.
  assign cnt_cur = vld_q_r ? rd_q_r : '0;
  assign cnt_inc = (&cnt_cur) ? cnt_cur : cnt_cur + COUNT_BITS'(1);

  assign tgt_full = prod_r[PW-1:16];
  assign tgt_ext  = (llh_pkg::ACC_W + 1)'(tgt_full);
  assign target   = tgt_ext[llh_pkg::ACC_W] ? '1 : tgt_ext[llh_pkg::ACC_W-1:0];
  assign acc_sum  = llh_pkg::sat_add64(acc_r, llh_pkg::ACC_W'(cnt_cur));

  always_ff @(posedge clk) begin
    if (cmd.rec_upd) mem[bkt_r] <= cnt_inc;
    rd_q_r  <= mem[rd_addr];
    vld_q_r <= valid_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      total_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
    end else if (cmd.clr) begin
      valid_r <= '0;
      total_r <= '0;
      min_r   <= '0;
      max_r   <= '0;
    end else if (cmd.rec_upd) begin
      valid_r[bkt_r] <= 1'b1;
      if (!(&total_r)) total_r <= total_r + COUNT_BITS'(1);
      if (sample_r > max_r) max_r <= sample_r;
      if ((total_r == '0) || (sample_r < min_r)) min_r <= sample_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_clamped;
      bkt_r    <= in_bkt;
      frac_r   <= in_fraction;
      mcand_r  <= PW'(total_r);
      prod_r   <= '0;
    end else if (cmd.mul_step) begin
      if (frac_r[0]) prod_r <= prod_r + mcand_r;
      mcand_r <= mcand_r << 1;
      frac_r  <= frac_r >> 1;
    end
    if (cmd.scan_start) begin
      scan_idx_r <= '0;
      acc_r      <= '0;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_last ? '0 : scan_idx_r + IDX_W'(1);
      acc_r      <= acc_sum;
    end
    case (cmd.pv_sel)
      llh_pkg::PV_ZERO: pv_r <= '0;
      llh_pkg::PV_HIT:  pv_r <= llh_pkg::bucket_bound(llh_pkg::LOG_W'(scan_idx_r));
      llh_pkg::PV_MAX:  pv_r <= max_r;
      default:          pv_r <= pv_r;
    endcase
  end

  assign st.total_zero = (total_r == '0);
  assign st.mul_done   = (frac_r == '0);
  assign st.hit        = (acc_sum >= target);
  assign st.last       = scan_last;

  assign total_ext            = llh_pkg::ACC_W'(total_r);
  assign out_percentile_value = pv_r;
  assign out_min_seen         = min_r;
  assign out_max_seen         = max_r;
  assign out_sample_count     = (total_ext > llh_pkg::CNT_OUT_MAX) ? '1
                                : total_ext[llh_pkg::CNT_OUT_W-1:0];

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |=> (total_r == '0) && (valid_r == '0) && (max_r == '0))
    else $error("clear left histogram state behind");

  a_record_counts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rec_upd |=> (total_r != '0) && (min_r <= max_r))
    else $error("record left total empty or extremes out of order");

endmodule

`default_nettype wire

// File: hdl/log2_latency_histogram.sv
//------------------------------------------------------------------------------
// log2_latency_histogram
// Log2-bucketed latency histogram with record, percentile query and clear.
//------------------------------------------------------------------------------
// Usage: each transaction on in_ch carries a command (record, query, clear),
// a signed sample and a Q1.16 fraction. Exactly one transaction leaves on
// out_ch per input, with the percentile (zero except for queries) and the
// minimum, maximum and sample count after that command.
// One command is handled at a time; in_ch.ready is high only when idle.
// A record reads its bucket counter on acceptance, writes it back in state
// S_REC and then shows its result in S_OUT. A query runs a shift-add
// multiply for the target, one remaining fraction bit per cycle (up to 17
// bits), then scans one bucket a cycle through the registered counter
// memory. A clear, or a query of an empty histogram, goes straight from
// idle to the output state. Reset drops every bucket valid bit at once, so
// no clearing pass is needed. A result waits in the output register while
// out_ch.ready is low, and no new command is taken until it leaves.
//------------------------------------------------------------------------------
`default_nettype none

module log2_latency_histogram #(
  parameter int NUM_BUCKETS = 64,
  parameter int COUNT_BITS  = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  llh_in_if.sink     in_ch,
  llh_out_if.source  out_ch
);

  llh_pkg::dp_cmd_t    cmd;
  llh_pkg::dp_status_t st;

  llh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .st         (st),
    .cmd        (cmd)
  );

  llh_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .st                   (st),
    .in_sample            (in_ch.sample),
    .in_fraction          (in_ch.fraction),
    .out_percentile_value (out_ch.percentile_value),
    .out_min_seen         (out_ch.min_seen),
    .out_max_seen         (out_ch.max_seen),
    .out_sample_count     (out_ch.sample_count)
  );

endmodule

`default_nettype wire

// File: sim/log2_latency_histogram_tb.sv
//------------------------------------------------------------------------------
// log2_latency_histogram_tb
// Drives record, percentile query, clear and unused commands into the
// histogram. A predictor of its own tracks the bucket counters and the
// extremes and works out every result, and a monitor compares each output
// transaction field by field. Both sides of the handshake stall at random,
// and the output is held off once for a long stretch.
//------------------------------------------------------------------------------
module log2_latency_histogram_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int NUM_BUCKETS  = 64;
  localparam int RANDOM_CMDS  = 900;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int HOLD_AFTER   = 650;
  localparam int CALM_FIRST   = 300;
  localparam int CALM_LAST    = 500;
  localparam int IDLE_PCT     = 6;

  // The command field has one code that the package leaves unnamed.
  localparam logic [llh_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct {
    logic [llh_pkg::CMD_W-1:0]           command;
    logic signed [llh_pkg::SAMPLE_W-1:0] sample;
    logic [llh_pkg::FRAC_W-1:0]          fraction;
  } hist_cmd_t;

  typedef struct {
    logic [llh_pkg::VAL_W-1:0]     pct;
    logic [llh_pkg::VAL_W-1:0]     min_v;
    logic [llh_pkg::VAL_W-1:0]     max_v;
    logic [llh_pkg::CNT_OUT_W-1:0] count;
  } hist_view_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  llh_in_if  in_ch();
  llh_out_if out_ch();

  log2_latency_histogram dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Predicted histogram contents.
  logic [31:0]               hist_bins [NUM_BUCKETS] = '{default: '0};
  logic [31:0]               hist_total = '0;
  logic [llh_pkg::VAL_W-1:0] hist_min   = '0;
  logic [llh_pkg::VAL_W-1:0] hist_max   = '0;

  hist_cmd_t  pending_cmds[$];
  hist_view_t expected_views[$];
  hist_cmd_t  cur_cmd;

  int cmds_queued   = 0;
  int cmds_accepted = 0;
  int views_checked = 0;
  int fail_count    = 0;
  int cycle_count   = 0;
  int hold_left     = 0;
  logic hold_done   = 1'b0;

  function automatic hist_view_t histogram_apply(hist_cmd_t c);
    hist_view_t                v;
    logic [llh_pkg::VAL_W-1:0] s;
    logic [llh_pkg::VAL_W-1:0] t;
    logic [63:0]               target;
    logic [63:0]               acc;
    logic                      first;
    logic                      hit;
    int                        b;
    v.pct = '0;
    case (c.command)
      llh_pkg::CMD_RECORD: begin
        s = c.sample[llh_pkg::SAMPLE_W-1] ? '0 : c.sample[llh_pkg::VAL_W-1:0];
        t = s;
        b = 0;
        while (t > 1) begin
          t = t >> 1;
          b++;
        end
        if (b > NUM_BUCKETS - 1) b = NUM_BUCKETS - 1;
        first = (hist_total == 0);
        if (hist_bins[b] != '1) hist_bins[b] = hist_bins[b] + 1;
        if (hist_total != '1) hist_total = hist_total + 1;
        if (s > hist_max) hist_max = s;
        if (first || s < hist_min) hist_min = s;
      end
      llh_pkg::CMD_QUERY: begin
        if (hist_total != 0) begin
          // At most 17 + 32 bits, so the target never needs saturation.
          target = (64'(c.fraction) * 64'(hist_total)) >> 16;
          acc = '0;
          hit = 1'b0;
          for (int i = 0; i < NUM_BUCKETS; i++) begin
            if (!hit) begin
              acc = acc + 64'(hist_bins[i]);
              if (acc >= target) begin
                hit = 1'b1;
                v.pct = (i + 1 >= llh_pkg::VAL_W) ? '1
                        : (llh_pkg::VAL_W'(1) << (i + 1)) - llh_pkg::VAL_W'(1);
              end
            end
          end
          // Only a fraction above 1.0 can leave every bucket short.
          if (!hit) v.pct = hist_max;
        end
      end
      llh_pkg::CMD_CLEAR: begin
        hist_bins  = '{default: '0};
        hist_total = '0;
        hist_min   = '0;
        hist_max   = '0;
      end
      default: begin
      end
    endcase
    v.min_v = hist_min;
    v.max_v = hist_max;
    v.count = hist_total;
    return v;
  endfunction

  task automatic queue_cmd(input logic [llh_pkg::CMD_W-1:0] command,
                           input logic [llh_pkg::SAMPLE_W-1:0] sample,
                           input logic [llh_pkg::FRAC_W-1:0] fraction);
    hist_cmd_t c;
    c.command  = command;
    c.sample   = sample;
    c.fraction = fraction;
    pending_cmds.push_back(c);
    cmds_queued++;
  endtask

  task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
    fail_count++;
    if (fail_count <= 10) begin
      $display("[%0t] result %0d: %s expected %0d, got %0d", $realtime, views_checked,
               field, exp_v, got_v);
    end
  endtask

  // Driver: offers pending commands and predicts each accepted transaction.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_views.push_back(histogram_apply(cur_cmd));
        cmds_accepted <= cmds_accepted + 1;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() != 0 &&
            ((cmds_accepted >= CALM_FIRST && cmds_accepted < CALM_LAST) ||
             $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur_cmd = pending_cmds.pop_front();
          in_ch.command  <= cur_cmd.command;
          in_ch.sample   <= cur_cmd.sample;
          in_ch.fraction <= cur_cmd.fraction;
          in_ch.valid    <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk) begin
    hist_view_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_views.size() == 0) begin
          note_mismatch("unexpected result, percentile_value", '0,
                        64'(out_ch.percentile_value));
        end else begin
          e = expected_views.pop_front();
          if (out_ch.percentile_value !== e.pct)
            note_mismatch("percentile_value", 64'(e.pct), 64'(out_ch.percentile_value));
          if (out_ch.min_seen !== e.min_v)
            note_mismatch("min_seen", 64'(e.min_v), 64'(out_ch.min_seen));
          if (out_ch.max_seen !== e.max_v)
            note_mismatch("max_seen", 64'(e.max_v), 64'(out_ch.max_seen));
          if (out_ch.sample_count !== e.count)
            note_mismatch("sample_count", 64'(e.count), 64'(out_ch.sample_count));
        end
        views_checked <= views_checked + 1;
      end
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
      end else if (views_checked >= CALM_FIRST && views_checked < CALM_LAST) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // One long output hold-off, so the block fills up and stalls its input.
  always @(posedge clk) begin
    if (!hold_done && views_checked >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    hist_cmd_t c;
    int        pick;
    int        sel;
    in_ch.valid    = 1'b0;
    in_ch.command  = '0;
    in_ch.sample   = '0;
    in_ch.fraction = '0;
    out_ch.ready   = 1'b0;

    // Directed part: empty histogram, sample extremes, query edges, unused command, clear.
    queue_cmd(llh_pkg::CMD_QUERY,  64'd0, 17'd32768);
    queue_cmd(llh_pkg::CMD_RECORD, 64'd0, 17'd0);
    queue_cmd(llh_pkg::CMD_RECORD, 64'd1, 17'd0);
    queue_cmd(llh_pkg::CMD_RECORD, 64'hFFFF_FFFF_FFFF_FFFF, 17'd0);
    queue_cmd(llh_pkg::CMD_RECORD, 64'h8000_0000_0000_0000, 17'h1FFFF);
    queue_cmd(llh_pkg::CMD_RECORD, 64'h7FFF_FFFF_FFFF_FFFF, 17'd0);
    queue_cmd(llh_pkg::CMD_RECORD, 64'd2, 17'd0);
    queue_cmd(llh_pkg::CMD_RECORD, 64'd3, 17'd0);
    queue_cmd(llh_pkg::CMD_QUERY,  64'd0, 17'd0);
    queue_cmd(llh_pkg::CMD_QUERY,  64'd0, 17'd65536);
    queue_cmd(llh_pkg::CMD_QUERY,  64'd0, 17'd65535);
    queue_cmd(llh_pkg::CMD_QUERY,  64'd0, 17'd65537);
    queue_cmd(llh_pkg::CMD_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 17'h1FFFF);
    queue_cmd(CMD_UNUSED,          64'hFFFF_FFFF_FFFF_FFFF, 17'h1FFFF);
    queue_cmd(llh_pkg::CMD_CLEAR,  64'd5, 17'd7);
    queue_cmd(llh_pkg::CMD_QUERY,  64'd0, 17'd65536);
    queue_cmd(llh_pkg::CMD_RECORD, 64'd1000, 17'd0);
    queue_cmd(llh_pkg::CMD_RECORD, 64'h4000_0000_0000_0000, 17'd0);
    queue_cmd(llh_pkg::CMD_RECORD, 64'h2000_0000_0000_0000, 17'd0);
    queue_cmd(llh_pkg::CMD_QUERY,  64'd0, 17'd65536);
    queue_cmd(llh_pkg::CMD_QUERY,  64'd0, 17'd32768);
    queue_cmd(llh_pkg::CMD_QUERY,  64'd0, 17'h1FFFF);
    queue_cmd(llh_pkg::CMD_CLEAR,  64'd0, 17'd0);

    // Random part: mostly records spread over all magnitudes, with queries
    // in between and an occasional clear so the histogram keeps refilling.
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      pick = $urandom_range(0, 99);
      c.sample   = {$urandom, $urandom};
      c.fraction = llh_pkg::FRAC_W'($urandom_range(0, 65536));
      if (pick < 68) begin
        c.command = llh_pkg::CMD_RECORD;
        sel = $urandom_range(0, 9);
        if (sel == 1) begin
          c.sample = llh_pkg::SAMPLE_W'($urandom_range(0, 3));
        end else if (sel != 0) begin
          c.sample = {1'b0, c.sample[llh_pkg::VAL_W-1:0]} >>
                     $urandom_range(0, llh_pkg::VAL_W - 1);
        end
      end else if (pick < 94) begin
        c.command = llh_pkg::CMD_QUERY;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
          c.fraction = $urandom_range(0, 1) ? 17'd65536 : 17'd0;
        end else if (sel == 1) begin
          c.fraction = llh_pkg::FRAC_W'($urandom_range(65537, 131071));
        end
      end else if (pick < 97) begin
        c.command = llh_pkg::CMD_CLEAR;
      end else begin
        c.command = CMD_UNUSED;
      end
      pending_cmds.push_back(c);
      cmds_queued++;
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (cmds_accepted != cmds_queued) @(posedge clk);
    while (expected_views.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_views.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
